### hdl/skvt_pkg.sv
package skvt_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int KEY_W            = 32;
   localparam int VALUE_W          = 32;

   // Codes of the operation field.
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_SET    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_ACT
   } state_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic                      cmp_en;
      logic                      update_en;
      logic                      insert_en;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] value;
   } cell_ctl_type;

endpackage

### hdl/skvt_req_if.sv
interface skvt_req_if
   import skvt_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [KEY_W-1:0]          key;
   logic signed [VALUE_W-1:0] new_value;
   logic signed [VALUE_W-1:0] default_value;

   modport source (output valid, operation, key, new_value, default_value, input ready);
   modport sink   (input valid, operation, key, new_value, default_value, output ready);
endinterface

### hdl/skvt_rsp_if.sv
interface skvt_rsp_if
   import skvt_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic signed [VALUE_W-1:0] result_value;
   logic                      full_error;

   modport source (output valid, hit, result_value, full_error, input ready);
   modport sink   (input valid, hit, result_value, full_error, output ready);
endinterface

### hdl/skvt_cell.sv
module skvt_cell
   import skvt_pkg::*;
(
   input  logic                      clock,
   input  cell_ctl_type              ctl,
   input  logic                      occupied,
   input  logic [KEY_W-1:0]          prev_key,
   input  logic signed [VALUE_W-1:0] prev_value,
   input  logic                      prev_lt,
   output logic [KEY_W-1:0]          key_out,
   output logic signed [VALUE_W-1:0] value_out,
   output logic                      lt_out,
   output logic                      eq_out
);

   logic [KEY_W-1:0]          key_ff,   key_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      lt_ff,    lt_in;
   logic                      eq_ff,    eq_in;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      if (ctl.cmp_en) begin
         lt_in = occupied && (key_ff < ctl.key);
         eq_in = occupied && (key_ff == ctl.key);
      end
      if (ctl.update_en && eq_ff) begin
         value_in = ctl.value;
      end
      // On insert, cells at or past the insert point move up by one; the
      // first of them takes the new pair.
      if (ctl.insert_en && !lt_ff) begin
         if (prev_lt) begin
            key_in   = ctl.key;
            value_in = ctl.value;
         end else begin
            key_in   = prev_key;
            value_in = prev_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign key_out   = key_ff;
   assign value_out = value_ff;
   assign lt_out    = lt_ff;
   assign eq_out    = eq_ff;

endmodule

### hdl/sorted_key_value_table.sv
// Channel   Dir  Handshake                Payload
// req_bus   in   valid/ready              operation, key, new_value, default_value
// rsp_bus   out  valid/ready              hit, result_value, full_error
//
// Each request passes a compare state, in which every cell compares its key
// with the request key, and an action state, in which the result is formed and
// the chain shifts. A new request is taken in the action state when the output
// register is free. Reset is synchronous and empties the table at once; there
// is no clearing pass. A response that is not taken stalls only the commit
// cycle of the next request, which then holds until the output register frees.
module sorted_key_value_table
   import skvt_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   skvt_req_if.sink   req_bus,
   skvt_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;

   // Request captured at acceptance.
   logic                      op_ff;
   logic [KEY_W-1:0]          key_ff;
   logic signed [VALUE_W-1:0] new_value_ff;
   logic signed [VALUE_W-1:0] default_value_ff;

   // Number of cells in use; occupied cells form a prefix of the chain.
   logic [CNT_W-1:0] count_ff, count_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_hit_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_full_ff;

   logic                      req_accept;
   logic                      out_free;
   logic                      commit;
   logic                      found;
   logic                      room;
   logic                      do_update;
   logic                      do_insert;
   logic signed [VALUE_W-1:0] hit_value;
   logic                      resp_hit;
   logic signed [VALUE_W-1:0] resp_value;
   logic                      resp_full;
   cell_ctl_type              ctl;

   logic [KEY_W-1:0]          cell_key   [CAPACITY];
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]       lt_vec;
   logic [CAPACITY-1:0]       eq_vec;
   logic [CAPACITY-1:0]       occ_vec;

   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign commit     = (state_ff == ST_ACT) && out_free;
   assign req_accept = req_bus.valid && req_bus.ready;

   // Next state and request acceptance.
   always_comb begin
      state_in      = state_ff;
      req_bus.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_ACT;
         end
         ST_ACT: begin
            req_bus.ready = out_free;
            if (out_free) begin
               state_in = req_bus.valid ? ST_CMP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff            <= req_bus.operation;
         key_ff           <= req_bus.key;
         new_value_ff     <= req_bus.new_value;
         default_value_ff <= req_bus.default_value;
      end
   end

   // At most one cell matches, so the matching value is an OR over the chain.
   always_comb begin
      hit_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (eq_vec[i]) begin
            hit_value = hit_value | cell_value[i];
         end
      end
   end

   assign found     = |eq_vec;
   assign room      = count_ff < CNT_W'(CAPACITY);
   assign do_update = commit && (op_ff == OP_SET) && found;
   assign do_insert = commit && (op_ff == OP_SET) && !found && room;

   always_comb begin
      resp_hit   = found;
      resp_full  = 1'b0;
      resp_value = new_value_ff;
      if (op_ff == OP_LOOKUP) begin
         resp_value = found ? hit_value : default_value_ff;
      end else if (!found && !room) begin
         resp_full  = 1'b1;
         resp_value = '0;
      end
   end

   assign ctl.cmp_en    = (state_ff == ST_CMP);
   assign ctl.update_en = do_update;
   assign ctl.insert_en = do_insert;
   assign ctl.key       = key_ff;
   assign ctl.value     = new_value_ff;

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // The cell chain. Cell zero sees a virtual neighbor whose key is below all.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occ_vec[i] = CNT_W'(i) < count_ff;
      if (i == 0) begin : g_head
         skvt_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occupied   (occ_vec[i]),
            .prev_key   ('0),
            .prev_value ('0),
            .prev_lt    (1'b1),
            .key_out    (cell_key[i]),
            .value_out  (cell_value[i]),
            .lt_out     (lt_vec[i]),
            .eq_out     (eq_vec[i])
         );
      end else begin : g_body
         skvt_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occupied   (occ_vec[i]),
            .prev_key   (cell_key[i-1]),
            .prev_value (cell_value[i-1]),
            .prev_lt    (lt_vec[i-1]),
            .key_out    (cell_key[i]),
            .value_out  (cell_value[i]),
            .lt_out     (lt_vec[i]),
            .eq_out     (eq_vec[i])
         );
      end
   end

   // Output register; a response is loaded only on commit, when it is free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_hit_ff   <= resp_hit;
         rsp_value_ff <= resp_value;
         rsp_full_ff  <= resp_full;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.hit          = rsp_hit_ff;
   assign rsp_bus.result_value = rsp_value_ff;
   assign rsp_bus.full_error   = rsp_full_ff;

`ifndef SYNTHESIS
   // The fill count never passes the number of cells.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // Keys are unique, so at most one cell matches.
   assert property (@(posedge clock) disable iff (reset) (state_ff == ST_ACT) |-> $onehot0(eq_vec))
      else $error("more than one cell matches the key");

   // Keys are sorted, so cells below the request key form a prefix of the chain.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACT) |-> ((lt_vec & (lt_vec + 1'b1)) == '0))
      else $error("cells below the key are not a prefix");

   // An insert grows the table by exactly one entry.
   assert property (@(posedge clock) disable iff (reset)
      do_insert |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the table");

   // A refused insert never reports a hit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |-> !rsp_hit_ff)
      else $error("full error together with hit");
`endif

endmodule
